// ----- hdl/drive_distance_p_controller_top_macros.svh -----
// assertion macros used by the checker
`ifndef DRIVE_DISTANCE_P_CONTROLLER_TOP_MACROS_SVH
`define DRIVE_DISTANCE_P_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define DDPC_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DDPC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ddpc_pkg.sv -----
package ddpc_pkg;

  localparam int POS_W      = 24;
  localparam int MOVED_W    = 24;
  localparam int TGT_W      = 21;
  localparam int PWR_W      = 8;
  localparam int PAR_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int Q8_W       = 8;
  localparam int ACC_W      = 42;
  localparam int MUL_AW     = 39;
  localparam int MUL_BW     = 24;
  localparam int MUL_PW     = MUL_AW + MUL_BW;
  localparam int DIV_QW     = 7;
  localparam int DIV_YW     = MUL_PW - FRAC_W;
  localparam int SAT_LO     = Q8_W + MOVED_W - 1;
  localparam int NUM_MOTORS = 4;
  localparam int IN_DATA_W  = NUM_MOTORS * POS_W;
  localparam int OUT_DATA_W = NUM_MOTORS * PWR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [1:0]         MODE_SLIDE      = 2'd1;
  localparam logic [1:0]         MODE_TURN       = 2'd2;
  localparam logic               CMD_START       = 1'b0;
  localparam logic [PWR_W-2:0]   PWR_MAX         = 7'd127;
  localparam logic [PAR_W-1:0]   RAMP_DIST_RESET = 16'd256;
  localparam logic [MUL_AW-1:0]  L_LIM           = {1'b1, {(MUL_AW-1){1'b0}}};
  localparam logic [MOVED_W-2:0] T_MAX           = {(MOVED_W-1){1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_TARGET,
    CFG_POWER,
    CFG_RAMP_EN,
    CFG_GAIN,
    CFG_RAMP_DIST,
    CFG_CM_PER_COUNT,
    CFG_ARC_PER_DEG
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULA,
    ST_CHECK,
    ST_MULB,
    ST_MULC,
    ST_DIV,
    ST_POWER,
    ST_RESULT
  } state_t;

endpackage

// ----- hdl/drive_distance_p_controller_top.sv -----
// Distance drive controller for a four-motor base.
// Input channel s_axis: tuser is the command (start a move / control tick),
// tdata carries the four encoder positions. Output channel m_axis: one item
// per input, tdata the four motor powers, tuser the done flag.
// Configuration registers are written through cfg_wen/cfg_index/cfg_data,
// by the user only while no item is in flight; the block does not enforce it.
// From input accept to output valid, a start command or a tick while no move
// is active goes straight to the result; the tick that ends a move runs one
// multiply round and the done check, a normal tick a second round and the
// power step, and a tick in the ramp-down a third round and the divide.
// The next item is taken only once the result is registered, never while an
// item is in flight. The two shared bit-serial multipliers (up to three
// rounds per item) and the serial divider of the ramp set the time taken.
// Reset clears the configuration to its defaults, the encoder offsets and
// moved distances, and ends any move. A stalled output keeps its item; the
// next result waits in the controller until the output register frees up.
module drive_distance_p_controller_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // left_front_pos, left_back_pos, right_front_pos, right_back_pos
  input  logic [ddpc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // left_front_power, left_back_power, right_front_power, right_back_power
  output logic [ddpc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // done_res
  output logic [0:0]                        m_axis_tuser,
  input  logic                              cfg_wen,
  input  logic [ddpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ddpc_pkg::*;

  function automatic logic [MOVED_W-1:0] moved_from(input logic neg,
                                                    input logic [MUL_PW-1:0] pr);
    logic               big;
    logic [MOVED_W-1:0] m;
    big = |pr[MUL_PW-1:SAT_LO];
    m   = {1'b0, pr[SAT_LO-1:Q8_W]};
    if (neg) begin
      moved_from = big ? {1'b1, {(MOVED_W-1){1'b0}}} : (~m + 1'b1);
    end else begin
      moved_from = big ? {1'b0, {(MOVED_W-1){1'b1}}} : m;
    end
  endfunction

  function automatic logic [PWR_W-1:0] power_from(input logic neg,
                                                  input logic [PWR_W-2:0] mag);
    logic [PWR_W-1:0] v;
    v = {1'b0, mag};
    power_from = neg ? (~v + 1'b1) : v;
  endfunction

  // configuration
  logic [1:0]        mode;
  logic [TGT_W-1:0]  target_amount;
  logic [PWR_W-1:0]  drive_power;
  logic              ramp_enable;
  logic [PAR_W-1:0]  gain;
  logic [PAR_W-1:0]  ramp_distance;
  logic [PAR_W-1:0]  cm_per_count;
  logic [PAR_W-1:0]  arc_per_degree;

  // move state
  logic [POS_W-1:0]   enc_offset [NUM_MOTORS];
  logic [MOVED_W-1:0] left_moved;
  logic [MOVED_W-1:0] right_moved;
  logic               active;

  // item and intermediate registers
  logic [POS_W-1:0]  pos [NUM_MOTORS];
  logic [MUL_AW-1:0] l_mag;
  logic [MUL_AW-1:0] r_mag;
  logic              l_neg;
  logic              r_neg;
  logic [MUL_BW-1:0] rem_mag;
  logic              rem_neg;
  logic              ramp;
  logic [PWR_W-1:0]  res_power [NUM_MOTORS];
  logic              res_done;
  logic [OUT_DATA_W-1:0] out_data;
  logic              out_done;
  logic              out_valid;

  state_t state, state_next;
  logic   mul_start;
  logic   div_start;
  logic   out_load;

  logic [MUL_AW-1:0] mul_a0, mul_a1;
  logic [MUL_BW-1:0] mul_b0, mul_b1;
  logic [MUL_PW-1:0] prod0, prod1;
  logic              mul_busy0, mul_busy1;
  logic              mul_idle;
  logic [DIV_QW-1:0] div_q0, div_q1;
  logic              div_busy0, div_busy1;
  logic [PAR_W-1:0]  ramp_win;

  // combinational datapath
  logic               is_slide, is_turn;
  logic [TGT_W-1:0]   t_abs;
  logic [MOVED_W:0]   diff, diff_mag;
  logic [MOVED_W-1:0] lm_abs, rm_abs;
  logic [MOVED_W-2:0] t_turn;
  logic [MOVED_W-1:0] t_cur;
  logic               done_hit;
  logic [ACC_W-1:0]   c_mag, c_s, p_s, l_raw, r_raw, l_full, r_full;
  logic [MOVED_W:0]   rem_l, rem_r, rem_abs, dist_ext;
  logic               ramp_hit;
  logic [POS_W:0]     dlt [NUM_MOTORS];
  logic [POS_W+1:0]   lsum, rsum, lsum_mag, rsum_mag;
  logic [PWR_W-2:0]   l_pmag, r_pmag;
  logic               l_out_neg, r_out_neg;

  assign is_slide = (mode == MODE_SLIDE);
  assign is_turn  = (mode == MODE_TURN);
  assign ramp_win = (ramp_distance == '0) ? PAR_W'(1) : ramp_distance;

  always_comb begin
    t_abs    = target_amount[TGT_W-1] ? (~target_amount + 1'b1) : target_amount;
    diff     = is_turn ? ({left_moved[MOVED_W-1], left_moved}
                          + {right_moved[MOVED_W-1], right_moved})
                       : ({left_moved[MOVED_W-1], left_moved}
                          - {right_moved[MOVED_W-1], right_moved});
    diff_mag = diff[MOVED_W] ? (~diff + 1'b1) : diff;
    lm_abs   = left_moved[MOVED_W-1] ? (~left_moved + 1'b1) : left_moved;
    rm_abs   = right_moved[MOVED_W-1] ? (~right_moved + 1'b1) : right_moved;

    t_turn   = (|prod0[MUL_PW-1:SAT_LO]) ? T_MAX : prod0[SAT_LO-1:Q8_W];
    t_cur    = is_turn ? {1'b0, t_turn} : MOVED_W'(t_abs);
    done_hit = (lm_abs >= t_cur) && (rm_abs >= t_cur);

    c_mag  = prod1[ACC_W-1:0];
    c_s    = diff[MOVED_W] ? (~c_mag + 1'b1) : c_mag;
    p_s    = {{(ACC_W-PWR_W-FRAC_W){drive_power[PWR_W-1]}}, drive_power,
              {FRAC_W{1'b0}}};
    l_raw  = is_slide ? p_s : (p_s - c_s);
    r_raw  = is_slide ? (~p_s + 1'b1)
                      : (is_turn ? ((~p_s + 1'b1) - c_s) : (p_s + c_s));
    l_full = l_raw[ACC_W-1] ? (~l_raw + 1'b1) : l_raw;
    r_full = r_raw[ACC_W-1] ? (~r_raw + 1'b1) : r_raw;

    rem_l    = {1'b0, t_cur} - {1'b0, lm_abs};
    rem_r    = {1'b0, t_cur} - {1'b0, rm_abs};
    rem_abs  = rem_l[MOVED_W] ? (~rem_l + 1'b1) : rem_l;
    dist_ext = (MOVED_W+1)'(ramp_win);
    ramp_hit = ramp_enable && (($signed(rem_l) <= $signed(dist_ext))
                               || ($signed(rem_r) <= $signed(dist_ext)));

    for (int i = 0; i < NUM_MOTORS; i++) begin
      dlt[i] = {pos[i][POS_W-1], pos[i]} - {enc_offset[i][POS_W-1], enc_offset[i]};
    end
    if (is_slide) begin
      lsum = {dlt[0][POS_W], dlt[0]} - {dlt[1][POS_W], dlt[1]};
      rsum = {dlt[3][POS_W], dlt[3]} - {dlt[2][POS_W], dlt[2]};
    end else begin
      lsum = {dlt[0][POS_W], dlt[0]} + {dlt[1][POS_W], dlt[1]};
      rsum = {dlt[2][POS_W], dlt[2]} + {dlt[3][POS_W], dlt[3]};
    end
    lsum_mag = lsum[POS_W+1] ? (~lsum + 1'b1) : lsum;
    rsum_mag = rsum[POS_W+1] ? (~rsum + 1'b1) : rsum;

    l_pmag = ramp ? div_q0
                  : ((|l_mag[MUL_AW-1:FRAC_W+PWR_W-1]) ? PWR_MAX
                                                       : l_mag[FRAC_W+PWR_W-2:FRAC_W]);
    r_pmag = ramp ? div_q1
                  : ((|r_mag[MUL_AW-1:FRAC_W+PWR_W-1]) ? PWR_MAX
                                                       : r_mag[FRAC_W+PWR_W-2:FRAC_W]);
    l_out_neg = l_neg ^ (ramp & rem_neg);
    r_out_neg = r_neg ^ (ramp & rem_neg);
  end

  // multiplier operands by phase
  always_comb begin
    unique case (state)
      ST_IDLE: begin
        mul_a0 = MUL_AW'(t_abs);
        mul_b0 = MUL_BW'(arc_per_degree);
        mul_a1 = MUL_AW'(diff_mag);
        mul_b1 = MUL_BW'(gain);
      end
      ST_CHECK: begin
        mul_a0 = MUL_AW'(lsum_mag);
        mul_b0 = MUL_BW'(cm_per_count);
        mul_a1 = MUL_AW'(rsum_mag);
        mul_b1 = MUL_BW'(cm_per_count);
      end
      default: begin
        mul_a0 = l_mag;
        mul_b0 = rem_mag;
        mul_a1 = r_mag;
        mul_b1 = rem_mag;
      end
    endcase
  end

  ddpc_mul u_mul0 (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a0),
    .b     (mul_b0),
    .busy  (mul_busy0),
    .prod  (prod0)
  );

  ddpc_mul u_mul1 (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a1),
    .b     (mul_b1),
    .busy  (mul_busy1),
    .prod  (prod1)
  );

  ddpc_div u_div0 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .y     (prod0[MUL_PW-1:FRAC_W]),
    .d     (ramp_win),
    .busy  (div_busy0),
    .q     (div_q0)
  );

  ddpc_div u_div1 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .y     (prod1[MUL_PW-1:FRAC_W]),
    .d     (ramp_win),
    .busy  (div_busy1),
    .q     (div_q1)
  );

  assign mul_idle = !mul_busy0 && !mul_busy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser[0] == CMD_START || !active) begin
            state_next = ST_RESULT;
          end else begin
            state_next = ST_MULA;
            mul_start  = 1'b1;
          end
        end
      end
      ST_MULA: begin
        if (mul_idle) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (done_hit) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_MULB;
          mul_start  = 1'b1;
        end
      end
      ST_MULB: begin
        if (mul_idle) begin
          if (ramp) begin
            state_next = ST_MULC;
            mul_start  = 1'b1;
          end else begin
            state_next = ST_POWER;
          end
        end
      end
      ST_MULC: begin
        if (mul_idle) begin
          state_next = ST_DIV;
          div_start  = 1'b1;
        end
      end
      ST_DIV: begin
        if (!div_busy0 && !div_busy1) begin
          state_next = ST_POWER;
        end
      end
      ST_POWER: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign out_load      = (state == ST_RESULT) && (!out_valid || m_axis_tready);

  // configuration and move state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= '0;
      target_amount  <= '0;
      drive_power    <= '0;
      ramp_enable    <= 1'b0;
      gain           <= '0;
      ramp_distance  <= RAMP_DIST_RESET;
      cm_per_count   <= '0;
      arc_per_degree <= '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        enc_offset[i] <= '0;
      end
      left_moved  <= '0;
      right_moved <= '0;
      active      <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          CFG_MODE:         mode           <= cfg_data[1:0];
          CFG_TARGET:       target_amount  <= cfg_data[TGT_W-1:0];
          CFG_POWER:        drive_power    <= cfg_data[PWR_W-1:0];
          CFG_RAMP_EN:      ramp_enable    <= cfg_data[0];
          CFG_GAIN:         gain           <= cfg_data[PAR_W-1:0];
          CFG_RAMP_DIST:    ramp_distance  <= cfg_data[PAR_W-1:0];
          CFG_CM_PER_COUNT: cm_per_count   <= cfg_data[PAR_W-1:0];
          CFG_ARC_PER_DEG:  arc_per_degree <= cfg_data[PAR_W-1:0];
        endcase
      end
      if (state == ST_IDLE && s_axis_tvalid && s_axis_tuser[0] == CMD_START) begin
        for (int i = 0; i < NUM_MOTORS; i++) begin
          enc_offset[i] <= s_axis_tdata[i*POS_W +: POS_W];
        end
        left_moved  <= '0;
        right_moved <= '0;
        active      <= 1'b1;
      end
      if (state == ST_CHECK && done_hit) begin
        for (int i = 0; i < NUM_MOTORS; i++) begin
          enc_offset[i] <= pos[i];
        end
        left_moved  <= '0;
        right_moved <= '0;
        active      <= 1'b0;
      end
      if (state == ST_MULB && mul_idle) begin
        left_moved  <= moved_from(lsum[POS_W+1], prod0);
        right_moved <= moved_from(rsum[POS_W+1], prod1);
      end
    end
  end

  // item payload and per-tick intermediates
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        pos[i]       <= s_axis_tdata[i*POS_W +: POS_W];
        res_power[i] <= '0;
      end
      res_done <= 1'b0;
    end
    if (state == ST_CHECK) begin
      l_mag   <= (l_full > ACC_W'(L_LIM)) ? L_LIM : l_full[MUL_AW-1:0];
      r_mag   <= (r_full > ACC_W'(L_LIM)) ? L_LIM : r_full[MUL_AW-1:0];
      l_neg   <= l_raw[ACC_W-1];
      r_neg   <= r_raw[ACC_W-1];
      rem_mag <= rem_abs[MUL_BW-1:0];
      rem_neg <= rem_l[MOVED_W];
      ramp    <= ramp_hit;
      if (done_hit) begin
        res_done <= 1'b1;
      end
    end
    if (state == ST_POWER) begin
      res_power[0] <= power_from(l_out_neg, l_pmag);
      res_power[1] <= power_from(l_out_neg ^ is_slide, l_pmag);
      res_power[2] <= power_from(r_out_neg, r_pmag);
      res_power[3] <= power_from(r_out_neg ^ is_slide, r_pmag);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {res_power[3], res_power[2], res_power[1], res_power[0]};
      out_done <= res_done;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_data;
  assign m_axis_tuser[0] = out_done;

endmodule

// ----- hdl/ddpc_mul.sv -----
module ddpc_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ddpc_pkg::MUL_AW-1:0]   a,
  input  logic [ddpc_pkg::MUL_BW-1:0]   b,
  output logic                          busy,
  output logic [ddpc_pkg::MUL_PW-1:0]   prod
);
  import ddpc_pkg::*;

  localparam int CNT_W = $clog2(MUL_BW);

  logic [MUL_AW-1:0] mcand;
  logic [MUL_AW:0]   hi;
  logic [MUL_AW:0]   sum;
  logic [MUL_BW-1:0] lo;
  logic [CNT_W-1:0]  cnt;

  // one multiplier bit per cycle, product shifts right into lo
  assign sum  = hi + (lo[0] ? {1'b0, mcand} : '0);
  assign prod = {hi[MUL_AW-1:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(MUL_BW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi <= {1'b0, sum[MUL_AW:1]};
      lo <= {sum[0], lo[MUL_BW-1:1]};
    end
  end

endmodule

// ----- hdl/ddpc_div.sv -----
module ddpc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ddpc_pkg::DIV_YW-1:0]   y,
  input  logic [ddpc_pkg::PAR_W-1:0]    d,
  output logic                          busy,
  output logic [ddpc_pkg::DIV_QW-1:0]   q
);
  import ddpc_pkg::*;

  localparam int CNT_W = $clog2(DIV_QW);

  logic              sat;
  logic [PAR_W-1:0]  r;
  logic [PAR_W:0]    r2;
  logic              ge;
  logic [DIV_QW-1:0] ylo;
  logic [DIV_QW-1:0] qq;
  logic [CNT_W-1:0]  cnt;

  // restoring division, one quotient bit per cycle; large quotients saturate
  assign r2 = {r, ylo[DIV_QW-1]};
  assign ge = (r2 >= {1'b0, d});
  assign q  = sat ? PWR_MAX : qq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIV_QW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat <= (y[DIV_YW-1:DIV_QW] >= (DIV_YW-DIV_QW)'(d));
      r   <= y[DIV_QW+PAR_W-1:DIV_QW];
      ylo <= y[DIV_QW-1:0];
      qq  <= '0;
    end else if (busy) begin
      r   <= ge ? PAR_W'(r2 - {1'b0, d}) : r2[PAR_W-1:0];
      qq  <= {qq[DIV_QW-2:0], ge};
      ylo <= {ylo[DIV_QW-2:0], 1'b0};
    end
  end

endmodule

// ----- hdl/ddpc_checker.sv -----
`include "drive_distance_p_controller_top_macros.svh"

module ddpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  `DDPC_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output item changed while stalled")

  // one item at a time: input closes right after an accept
  `DDPC_ASSERT_NEXT(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while an item is in flight")

  // a finishing tick stops all motors
  `DDPC_ASSERT_NOW(a_done_zero, clk, rst, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 32'd0, "done item with nonzero power")

  // powers stay within +-127
  `DDPC_ASSERT_NOW(a_pwr_range, clk, rst, m_axis_tvalid, (m_axis_tdata[7:0] != 8'h80) && (m_axis_tdata[15:8] != 8'h80) && (m_axis_tdata[23:16] != 8'h80) && (m_axis_tdata[31:24] != 8'h80), "power out of range")

endmodule

bind drive_distance_p_controller_top ddpc_checker u_ddpc_checker (.*);
